/* hw/rtl/sdp_pkg.sv */
package sdp_pkg;

    localparam int unsigned MAX_DEPTH = 16;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_DIV10 = 2'd1;

    localparam logic [7:0] SYNC_BYTE = 8'h05;
    localparam logic [7:0] ACK_BYTE  = 8'h01;
    localparam logic [7:0] REQ_BYTE  = 8'hF7;

    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    localparam logic [1:0] REG_ENTRIES_USED  = 2'd0;
    localparam logic [1:0] REG_IDLE_PAUSE    = 2'd1;
    localparam logic [1:0] REG_REPLY_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_CYCLE_WAIT    = 2'd3;

    localparam logic [4:0]  ENTRIES_USED_RST  = 5'd16;
    localparam logic [15:0] IDLE_PAUSE_RST    = 16'd100;
    localparam logic [15:0] REPLY_TIMEOUT_RST = 16'd2000;
    localparam logic [15:0] CYCLE_WAIT_RST    = 16'd10000;
    localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;

    localparam logic [31:0] RECIP_TEN   = 32'hCCCCCCCD;
    localparam int unsigned RECIP_SHIFT = 35;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  rx_byte;
        logic [3:0]  load_index;
        logic [15:0] load_address;
        logic [2:0]  load_length;
        logic [1:0]  load_scale_mode;
    } cmd_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  tx_byte;
        logic [3:0]  published_index;
        logic [31:0] published_value;
        logic        last_of_run;
    } rsp_item_t;

    typedef struct packed {
        logic [1:0]  scale_mode;
        logic [2:0]  length;
        logic [15:0] address;
    } entry_t;

    typedef enum logic [3:0] {
        PH_SYNC   = 4'b0001,
        PH_IDLE   = 4'b0010,
        PH_LISTEN = 4'b0100,
        PH_WAIT   = 4'b1000
    } phase_t;

    typedef enum logic [4:0] {
        ACT_NONE        = 5'd0,
        ACT_ACCEPT      = 5'd1,
        ACT_WRITE_ENTRY = 5'd2,
        ACT_EMIT_ACK    = 5'd3,
        ACT_ENTER_IDLE  = 5'd4,
        ACT_GATHER      = 5'd5,
        ACT_STORE       = 5'd6,
        ACT_PTR_INC     = 5'd7,
        ACT_PTR_WRAP    = 5'd8,
        ACT_EMIT_F7     = 5'd9,
        ACT_EMIT_AHI    = 5'd10,
        ACT_EMIT_ALO    = 5'd11,
        ACT_EMIT_LEN    = 5'd12,
        ACT_ELAPSED_INC = 5'd13,
        ACT_TIMEOUT     = 5'd14,
        ACT_PUB_CLEAR   = 5'd15,
        ACT_EMIT_PUB    = 5'd16,
        ACT_PUB_INC     = 5'd17,
        ACT_PHASE_SYNC  = 5'd18
    } act_t;

    typedef enum logic [4:0] {
        C_NEVER              = 5'd0,
        C_ALWAYS             = 5'd1,
        C_NO_INPUT           = 5'd2,
        C_OP_TICK            = 5'd3,
        C_OP_BYTE            = 5'd4,
        C_OP_NOT_LOAD        = 5'd5,
        C_PH_LISTEN          = 5'd6,
        C_NOT_SYNC_BYTE      = 5'd7,
        C_PAUSE_NZ           = 5'd8,
        C_GATH_FULL          = 5'd9,
        C_GATH_NE_LEN        = 5'd10,
        C_LAST_ENTRY         = 5'd11,
        C_PH_IDLE            = 5'd12,
        C_PH_NOT_WAIT        = 5'd13,
        C_ELAPSED_LE_WAIT    = 5'd14,
        C_PUB_LAST           = 5'd15,
        C_ELAPSED_LT_PAUSE   = 5'd16,
        C_ELAPSED_LE_TIMEOUT = 5'd17
    } cond_t;

    typedef struct packed {
        act_t act;
        logic go;
    } ctrl_t;

    typedef struct packed {
        logic no_input;
        logic op_tick;
        logic op_byte;
        logic op_load;
        logic ph_sync;
        logic ph_idle;
        logic ph_listen;
        logic ph_wait;
        logic sync_byte;
        logic pause_nz;
        logic gath_full;
        logic gath_eq_len;
        logic last_entry;
        logic elapsed_lt_pause;
        logic elapsed_le_timeout;
        logic elapsed_le_wait;
        logic pub_last;
        logic out_free;
    } status_t;

endpackage

/* hw/rtl/sdp_seq.sv */
module sdp_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  sdp_pkg::status_t status,
    output sdp_pkg::ctrl_t   ctrl
);

    localparam int unsigned PC_W = 6;

    localparam logic [PC_W-1:0] S_FETCH    = 6'd0;
    localparam logic [PC_W-1:0] S_DECODE   = 6'd1;
    localparam logic [PC_W-1:0] S_BYTE     = 6'd5;
    localparam logic [PC_W-1:0] S_TAKE     = 6'd10;
    localparam logic [PC_W-1:0] S_REQ      = 6'd16;
    localparam logic [PC_W-1:0] S_WRAP     = 6'd20;
    localparam logic [PC_W-1:0] S_TICK     = 6'd21;
    localparam logic [PC_W-1:0] S_PUB_RD   = 6'd27;
    localparam logic [PC_W-1:0] S_PUB_DONE = 6'd30;
    localparam logic [PC_W-1:0] S_TICK_IDL = 6'd31;
    localparam logic [PC_W-1:0] S_TICK_LSN = 6'd33;
    localparam logic [PC_W-1:0] S_LAST     = 6'd34;

    typedef struct packed {
        sdp_pkg::act_t   act;
        sdp_pkg::cond_t  cond;
        logic [PC_W-1:0] target;
    } uword_t;

    function automatic uword_t rom(input logic [PC_W-1:0] addr);
        uword_t w;
        w = '{sdp_pkg::ACT_NONE, sdp_pkg::C_ALWAYS, S_FETCH};
        case (addr)
            6'd0:  w = '{sdp_pkg::ACT_ACCEPT,      sdp_pkg::C_NO_INPUT,           S_FETCH};
            6'd1:  w = '{sdp_pkg::ACT_NONE,        sdp_pkg::C_OP_TICK,            S_TICK};
            6'd2:  w = '{sdp_pkg::ACT_NONE,        sdp_pkg::C_OP_BYTE,            S_BYTE};
            6'd3:  w = '{sdp_pkg::ACT_NONE,        sdp_pkg::C_OP_NOT_LOAD,        S_FETCH};
            6'd4:  w = '{sdp_pkg::ACT_WRITE_ENTRY, sdp_pkg::C_ALWAYS,             S_FETCH};
            6'd5:  w = '{sdp_pkg::ACT_NONE,        sdp_pkg::C_PH_LISTEN,          S_TAKE};
            6'd6:  w = '{sdp_pkg::ACT_NONE,        sdp_pkg::C_NOT_SYNC_BYTE,      S_FETCH};
            6'd7:  w = '{sdp_pkg::ACT_EMIT_ACK,    sdp_pkg::C_NEVER,              S_FETCH};
            6'd8:  w = '{sdp_pkg::ACT_ENTER_IDLE,  sdp_pkg::C_PAUSE_NZ,           S_FETCH};
            6'd9:  w = '{sdp_pkg::ACT_NONE,        sdp_pkg::C_ALWAYS,             S_REQ};
            6'd10: w = '{sdp_pkg::ACT_NONE,        sdp_pkg::C_GATH_FULL,          S_FETCH};
            6'd11: w = '{sdp_pkg::ACT_GATHER,      sdp_pkg::C_NEVER,              S_FETCH};
            6'd12: w = '{sdp_pkg::ACT_NONE,        sdp_pkg::C_GATH_NE_LEN,        S_FETCH};
            6'd13: w = '{sdp_pkg::ACT_STORE,       sdp_pkg::C_LAST_ENTRY,         S_WRAP};
            6'd14: w = '{sdp_pkg::ACT_PTR_INC,     sdp_pkg::C_NEVER,              S_FETCH};
            6'd15: w = '{sdp_pkg::ACT_ENTER_IDLE,  sdp_pkg::C_PAUSE_NZ,           S_FETCH};
            6'd16: w = '{sdp_pkg::ACT_EMIT_F7,     sdp_pkg::C_NEVER,              S_FETCH};
            6'd17: w = '{sdp_pkg::ACT_EMIT_AHI,    sdp_pkg::C_NEVER,              S_FETCH};
            6'd18: w = '{sdp_pkg::ACT_EMIT_ALO,    sdp_pkg::C_NEVER,              S_FETCH};
            6'd19: w = '{sdp_pkg::ACT_EMIT_LEN,    sdp_pkg::C_ALWAYS,             S_FETCH};
            6'd20: w = '{sdp_pkg::ACT_PTR_WRAP,    sdp_pkg::C_ALWAYS,             S_FETCH};
            6'd21: w = '{sdp_pkg::ACT_ELAPSED_INC, sdp_pkg::C_NEVER,              S_FETCH};
            6'd22: w = '{sdp_pkg::ACT_NONE,        sdp_pkg::C_PH_IDLE,            S_TICK_IDL};
            6'd23: w = '{sdp_pkg::ACT_NONE,        sdp_pkg::C_PH_LISTEN,          S_TICK_LSN};
            6'd24: w = '{sdp_pkg::ACT_NONE,        sdp_pkg::C_PH_NOT_WAIT,        S_FETCH};
            6'd25: w = '{sdp_pkg::ACT_NONE,        sdp_pkg::C_ELAPSED_LE_WAIT,    S_FETCH};
            6'd26: w = '{sdp_pkg::ACT_PUB_CLEAR,   sdp_pkg::C_NEVER,              S_FETCH};
            6'd27: w = '{sdp_pkg::ACT_NONE,        sdp_pkg::C_NEVER,              S_FETCH};
            6'd28: w = '{sdp_pkg::ACT_EMIT_PUB,    sdp_pkg::C_PUB_LAST,           S_PUB_DONE};
            6'd29: w = '{sdp_pkg::ACT_PUB_INC,     sdp_pkg::C_ALWAYS,             S_PUB_RD};
            6'd30: w = '{sdp_pkg::ACT_PHASE_SYNC,  sdp_pkg::C_ALWAYS,             S_FETCH};
            6'd31: w = '{sdp_pkg::ACT_NONE,        sdp_pkg::C_ELAPSED_LT_PAUSE,   S_FETCH};
            6'd32: w = '{sdp_pkg::ACT_NONE,        sdp_pkg::C_ALWAYS,             S_REQ};
            6'd33: w = '{sdp_pkg::ACT_NONE,        sdp_pkg::C_ELAPSED_LE_TIMEOUT, S_FETCH};
            6'd34: w = '{sdp_pkg::ACT_TIMEOUT,     sdp_pkg::C_ALWAYS,             S_FETCH};
            default: w = '{sdp_pkg::ACT_NONE, sdp_pkg::C_ALWAYS, S_FETCH};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          word;
    logic            cond_true;
    logic            is_emit;
    logic            go;

    assign word = rom(pc_reg);

    always_comb
    begin
        case (word.cond)
            sdp_pkg::C_NEVER:              cond_true = 1'b0;
            sdp_pkg::C_ALWAYS:             cond_true = 1'b1;
            sdp_pkg::C_NO_INPUT:           cond_true = status.no_input;
            sdp_pkg::C_OP_TICK:            cond_true = status.op_tick;
            sdp_pkg::C_OP_BYTE:            cond_true = status.op_byte;
            sdp_pkg::C_OP_NOT_LOAD:        cond_true = !status.op_load;
            sdp_pkg::C_PH_LISTEN:          cond_true = status.ph_listen;
            sdp_pkg::C_NOT_SYNC_BYTE:      cond_true = !(status.ph_sync && status.sync_byte);
            sdp_pkg::C_PAUSE_NZ:           cond_true = status.pause_nz;
            sdp_pkg::C_GATH_FULL:          cond_true = status.gath_full;
            sdp_pkg::C_GATH_NE_LEN:        cond_true = !status.gath_eq_len;
            sdp_pkg::C_LAST_ENTRY:         cond_true = status.last_entry;
            sdp_pkg::C_PH_IDLE:            cond_true = status.ph_idle;
            sdp_pkg::C_PH_NOT_WAIT:        cond_true = !status.ph_wait;
            sdp_pkg::C_ELAPSED_LE_WAIT:    cond_true = status.elapsed_le_wait;
            sdp_pkg::C_PUB_LAST:           cond_true = status.pub_last;
            sdp_pkg::C_ELAPSED_LT_PAUSE:   cond_true = status.elapsed_lt_pause;
            sdp_pkg::C_ELAPSED_LE_TIMEOUT: cond_true = status.elapsed_le_timeout;
            default:                       cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        is_emit = word.act inside {sdp_pkg::ACT_EMIT_ACK, sdp_pkg::ACT_EMIT_F7,
                                   sdp_pkg::ACT_EMIT_AHI, sdp_pkg::ACT_EMIT_ALO,
                                   sdp_pkg::ACT_EMIT_LEN, sdp_pkg::ACT_EMIT_PUB};
        go = !(is_emit && !status.out_free);
        if (!go)
        begin
            pc_next = pc_reg;
        end
        else if (cond_true)
        begin
            pc_next = word.target;
        end
        else
        begin
            pc_next = pc_reg + 6'd1;
        end
    end

    assign ctrl.act = word.act;
    assign ctrl.go  = go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    a_fetch_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == S_FETCH && !status.no_input) |=> (pc_reg == S_DECODE))
        else $error("fetch did not advance after an accepted item");

    a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> (pc_reg == $past(pc_reg)))
        else $error("step counter moved while an emit step was blocked");

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= S_LAST)
        else $error("step counter left the program");

endmodule

/* hw/rtl/sdp_dp.sv */
module sdp_dp #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  sdp_pkg::cmd_item_t cmd_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sdp_pkg::rsp_item_t rsp_item,
    input  sdp_pkg::ctrl_t     ctrl,
    output sdp_pkg::status_t   status
);

    localparam int unsigned USABLE = (TABLE_DEPTH < sdp_pkg::MAX_DEPTH) ? TABLE_DEPTH
                                                                         : sdp_pkg::MAX_DEPTH;
    localparam int unsigned IDX_W = (USABLE > 1) ? $clog2(USABLE) : 1;
    localparam logic [4:0] USABLE_CNT = 5'(USABLE);

    logic [4:0]          entries_used_reg, entries_used_next;
    logic [15:0]         idle_pause_reg, idle_pause_next;
    logic [15:0]         reply_timeout_reg, reply_timeout_next;
    logic [15:0]         cycle_wait_reg, cycle_wait_next;

    sdp_pkg::phase_t     phase_reg, phase_next;
    logic [3:0]          ptr_reg, ptr_next;
    logic [2:0]          gath_reg, gath_next;
    logic [31:0]         asm_reg, asm_next;
    logic [15:0]         elapsed_reg, elapsed_next;
    logic [3:0]          pub_cnt_reg, pub_cnt_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [USABLE-1:0]   value_ok_reg;

    sdp_pkg::cmd_item_t  item_reg, item_next;
    sdp_pkg::rsp_item_t  rsp_reg, rsp_next;
    sdp_pkg::rsp_item_t  emit_item;
    logic                emit;
    sdp_pkg::entry_t     entry_mem [USABLE];
    sdp_pkg::entry_t     entry_rd_reg;
    sdp_pkg::entry_t     entry_new;
    logic [31:0]         value_mem [USABLE];
    logic [31:0]         value_rd_reg;
    logic [63:0]         prod_reg;
    logic [31:0]         quotient;
    logic [31:0]         store_data;
    logic                load_we;
    logic                store_we;
    logic [4:0]          used;

    always_comb
    begin
        if (entries_used_reg == 5'd0)
        begin
            used = 5'd1;
        end
        else if (entries_used_reg > USABLE_CNT)
        begin
            used = USABLE_CNT;
        end
        else
        begin
            used = entries_used_reg;
        end
    end

    assign quotient  = 32'(prod_reg[63:sdp_pkg::RECIP_SHIFT]);
    assign entry_new = '{scale_mode: item_reg.load_scale_mode,
                         length:     item_reg.load_length,
                         address:    item_reg.load_address};
    assign load_we   = ctrl.go && (ctrl.act == sdp_pkg::ACT_WRITE_ENTRY)
                       && ({1'b0, item_reg.load_index} < USABLE_CNT);
    assign store_we  = ctrl.go && (ctrl.act == sdp_pkg::ACT_STORE)
                       && ((entry_rd_reg.scale_mode == sdp_pkg::MODE_RAW)
                           || (entry_rd_reg.scale_mode == sdp_pkg::MODE_DIV10));
    assign store_data = (entry_rd_reg.scale_mode == sdp_pkg::MODE_RAW) ? asm_reg : quotient;

    always_comb
    begin
        entries_used_next  = entries_used_reg;
        idle_pause_next    = idle_pause_reg;
        reply_timeout_next = reply_timeout_reg;
        cycle_wait_next    = cycle_wait_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                sdp_pkg::REG_ENTRIES_USED:  entries_used_next  = cfg_data[4:0];
                sdp_pkg::REG_IDLE_PAUSE:    idle_pause_next    = cfg_data;
                sdp_pkg::REG_REPLY_TIMEOUT: reply_timeout_next = cfg_data;
                sdp_pkg::REG_CYCLE_WAIT:    cycle_wait_next    = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        ptr_next     = ptr_reg;
        gath_next    = gath_reg;
        asm_next     = asm_reg;
        elapsed_next = elapsed_reg;
        pub_cnt_next = pub_cnt_reg;
        item_next    = item_reg;
        emit         = 1'b0;
        emit_item    = '0;
        if (ctrl.go)
        begin
            case (ctrl.act)
                sdp_pkg::ACT_ACCEPT:
                begin
                    if (cmd_valid)
                    begin
                        item_next = cmd_item;
                    end
                end
                sdp_pkg::ACT_EMIT_ACK:
                begin
                    emit                  = 1'b1;
                    emit_item.tx_byte     = sdp_pkg::ACK_BYTE;
                    emit_item.last_of_run = (idle_pause_reg != 16'd0);
                end
                sdp_pkg::ACT_ENTER_IDLE:
                begin
                    elapsed_next = '0;
                    phase_next   = sdp_pkg::PH_IDLE;
                end
                sdp_pkg::ACT_GATHER:
                begin
                    asm_next  = asm_reg | (32'(item_reg.rx_byte) << {gath_reg[1:0], 3'b000});
                    gath_next = gath_reg + 3'd1;
                end
                sdp_pkg::ACT_PTR_INC:
                begin
                    ptr_next = ptr_reg + 4'd1;
                end
                sdp_pkg::ACT_PTR_WRAP:
                begin
                    ptr_next   = '0;
                    phase_next = sdp_pkg::PH_WAIT;
                end
                sdp_pkg::ACT_EMIT_F7:
                begin
                    emit              = 1'b1;
                    emit_item.tx_byte = sdp_pkg::REQ_BYTE;
                end
                sdp_pkg::ACT_EMIT_AHI:
                begin
                    emit              = 1'b1;
                    emit_item.tx_byte = entry_rd_reg.address[15:8];
                end
                sdp_pkg::ACT_EMIT_ALO:
                begin
                    emit              = 1'b1;
                    emit_item.tx_byte = entry_rd_reg.address[7:0];
                end
                sdp_pkg::ACT_EMIT_LEN:
                begin
                    emit                  = 1'b1;
                    emit_item.tx_byte     = {5'd0, entry_rd_reg.length};
                    emit_item.last_of_run = 1'b1;
                    gath_next             = '0;
                    asm_next              = '0;
                    phase_next            = sdp_pkg::PH_LISTEN;
                end
                sdp_pkg::ACT_ELAPSED_INC:
                begin
                    if (elapsed_reg != sdp_pkg::ELAPSED_MAX)
                    begin
                        elapsed_next = elapsed_reg + 16'd1;
                    end
                end
                sdp_pkg::ACT_TIMEOUT:
                begin
                    gath_next    = '0;
                    asm_next     = '0;
                    elapsed_next = '0;
                    phase_next   = sdp_pkg::PH_SYNC;
                end
                sdp_pkg::ACT_PUB_CLEAR:
                begin
                    pub_cnt_next = '0;
                end
                sdp_pkg::ACT_EMIT_PUB:
                begin
                    emit                      = 1'b1;
                    emit_item.result_kind     = sdp_pkg::KIND_VALUE;
                    emit_item.published_index = pub_cnt_reg;
                    emit_item.published_value = value_rd_reg;
                    emit_item.last_of_run     = status.pub_last;
                end
                sdp_pkg::ACT_PUB_INC:
                begin
                    pub_cnt_next = pub_cnt_reg + 4'd1;
                end
                sdp_pkg::ACT_PHASE_SYNC:
                begin
                    phase_next = sdp_pkg::PH_SYNC;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (emit)
        begin
            rsp_next       = emit_item;
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_used_reg  <= sdp_pkg::ENTRIES_USED_RST;
            idle_pause_reg    <= sdp_pkg::IDLE_PAUSE_RST;
            reply_timeout_reg <= sdp_pkg::REPLY_TIMEOUT_RST;
            cycle_wait_reg    <= sdp_pkg::CYCLE_WAIT_RST;
            phase_reg         <= sdp_pkg::PH_SYNC;
            ptr_reg           <= '0;
            gath_reg          <= '0;
            asm_reg           <= '0;
            elapsed_reg       <= '0;
            pub_cnt_reg       <= '0;
            rsp_valid_reg     <= 1'b0;
            value_ok_reg      <= '0;
        end
        else
        begin
            entries_used_reg  <= entries_used_next;
            idle_pause_reg    <= idle_pause_next;
            reply_timeout_reg <= reply_timeout_next;
            cycle_wait_reg    <= cycle_wait_next;
            phase_reg         <= phase_next;
            ptr_reg           <= ptr_next;
            gath_reg          <= gath_next;
            asm_reg           <= asm_next;
            elapsed_reg       <= elapsed_next;
            pub_cnt_reg       <= pub_cnt_next;
            rsp_valid_reg     <= rsp_valid_next;
            if (store_we)
            begin
                value_ok_reg[ptr_reg[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
        prod_reg <= {32'd0, asm_reg} * {32'd0, sdp_pkg::RECIP_TEN};
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            entry_mem[item_reg.load_index[IDX_W-1:0]] <= entry_new;
        end
        entry_rd_reg <= entry_mem[ptr_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            value_mem[ptr_reg[IDX_W-1:0]] <= store_data;
        end
        value_rd_reg <= value_ok_reg[pub_cnt_reg[IDX_W-1:0]]
                        ? value_mem[pub_cnt_reg[IDX_W-1:0]] : 32'd0;
    end

    assign cmd_stall = (ctrl.act != sdp_pkg::ACT_ACCEPT);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    assign status.no_input           = !cmd_valid;
    assign status.op_tick            = (item_reg.operation == sdp_pkg::OP_TICK);
    assign status.op_byte            = (item_reg.operation == sdp_pkg::OP_BYTE);
    assign status.op_load            = (item_reg.operation == sdp_pkg::OP_LOAD);
    assign status.ph_sync            = (phase_reg == sdp_pkg::PH_SYNC);
    assign status.ph_idle            = (phase_reg == sdp_pkg::PH_IDLE);
    assign status.ph_listen          = (phase_reg == sdp_pkg::PH_LISTEN);
    assign status.ph_wait            = (phase_reg == sdp_pkg::PH_WAIT);
    assign status.sync_byte          = (item_reg.rx_byte == sdp_pkg::SYNC_BYTE);
    assign status.pause_nz           = (idle_pause_reg != 16'd0);
    assign status.gath_full          = (gath_reg >= 3'd4);
    assign status.gath_eq_len        = (gath_reg == entry_rd_reg.length);
    assign status.last_entry         = (({1'b0, ptr_reg} + 5'd1) >= used);
    assign status.elapsed_lt_pause   = (elapsed_reg < idle_pause_reg);
    assign status.elapsed_le_timeout = (elapsed_reg <= reply_timeout_reg);
    assign status.elapsed_le_wait    = (elapsed_reg <= cycle_wait_reg);
    assign status.pub_last           = ({1'b0, pub_cnt_reg} == (used - 5'd1));
    assign status.out_free           = !rsp_valid_reg || !rsp_stall;

    a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!rsp_valid_reg || !rsp_stall))
        else $error("result loaded over a waiting item");

    a_gath_bound: assert property (@(posedge clk) disable iff (!rst_n)
        gath_reg <= 3'd4)
        else $error("reply byte count past four");

    a_tx_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.result_kind == sdp_pkg::KIND_TX))
        |-> (rsp_reg.published_value == 32'd0 && rsp_reg.published_index == 4'd0))
        else $error("transmit item carries value fields");

endmodule

/* hw/rtl/serial_datapoint_poller_core.sv */
// Channel  Signals                          Direction  Moves
// cmd      cmd_valid, cmd_stall, cmd_item   in         tick, rx byte or table load item
// rsp      rsp_valid, rsp_stall, rsp_item   out        tx byte or published value item
// cfg      cfg_we, cfg_index, cfg_data      in         register write, no read-back
//
// A step counter walks a control ROM one step a cycle, holding on a blocked emit step.
// A request burst costs 4 emit steps; a publish emits one value item per used entry.
// The output register frees the sequencer unless it must emit while rsp_stall holds a waiting item.
// Reset: sync phase, registers at defaults, stored values read zero through valid bits.
// cmd_stall is low only on the fetch step.
module serial_datapoint_poller_core #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  sdp_pkg::cmd_item_t cmd_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sdp_pkg::rsp_item_t rsp_item
);

    sdp_pkg::ctrl_t   ctrl;
    sdp_pkg::status_t status;

    sdp_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    sdp_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .ctrl      (ctrl),
        .status    (status)
    );

endmodule

/* tb/serial_datapoint_poller_core_tb.sv */
module serial_datapoint_poller_core_tb;

    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;

    localparam logic [1:0] MODE_KEEP = 2'd2;
    localparam logic [1:0] MODE_ODD  = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    sdp_pkg::cmd_item_t  cmd_item = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    sdp_pkg::rsp_item_t  rsp_item;

    serial_datapoint_poller_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    always #5 clk = ~clk;

    // poller state as seen from the link
    logic [4:0]  cfg_entries;
    logic [15:0] cfg_pause;
    logic [15:0] cfg_timeout;
    logic [15:0] cfg_wait;
    sdp_pkg::phase_t ph;
    logic [3:0]  ptr;
    logic [2:0]  gathered;
    logic [31:0] assembly;
    logic [15:0] elapsed;
    sdp_pkg::entry_t entry_tab [16];
    logic [31:0] value_tab [16];

    sdp_pkg::rsp_item_t link_out_q [$];
    sdp_pkg::rsp_item_t held_out;
    bit          have_held;

    bit idling = 1'b1;
    int stall_hold = 0;
    int mismatches = 0;
    int items_sent = 0;
    int outs_seen = 0;
    int values_seen = 0;
    int settings_applied = 0;
    int quiet_cycles = 0;

    function automatic void push_out(logic kind, logic [7:0] tx, logic [3:0] idx,
                                     logic [31:0] val);
        if (have_held)
            link_out_q.push_back(held_out);
        held_out.result_kind     = kind;
        held_out.tx_byte         = tx;
        held_out.published_index = idx;
        held_out.published_value = val;
        held_out.last_of_run     = 1'b0;
        have_held = 1'b1;
    endfunction

    function automatic int used_entries();
        if (cfg_entries == 5'd0)
            return 1;
        if (cfg_entries > sdp_pkg::MAX_DEPTH)
            return sdp_pkg::MAX_DEPTH;
        return int'(cfg_entries);
    endfunction

    function automatic void send_request();
        sdp_pkg::entry_t e;
        e = entry_tab[ptr];
        push_out(sdp_pkg::KIND_TX, sdp_pkg::REQ_BYTE, 4'd0, 32'd0);
        push_out(sdp_pkg::KIND_TX, e.address[15:8], 4'd0, 32'd0);
        push_out(sdp_pkg::KIND_TX, e.address[7:0], 4'd0, 32'd0);
        push_out(sdp_pkg::KIND_TX, {5'd0, e.length}, 4'd0, 32'd0);
        gathered = '0;
        assembly = '0;
        ph = sdp_pkg::PH_LISTEN;
    endfunction

    function automatic void enter_idle();
        elapsed = '0;
        ph = sdp_pkg::PH_IDLE;
        if (cfg_pause == 16'd0)
            send_request();
    endfunction

    function automatic void take_byte(logic [7:0] b);
        sdp_pkg::entry_t e;
        if (gathered >= 3'd4)
            return;
        assembly = assembly | (32'(b) << (8 * gathered));
        gathered = gathered + 3'd1;
        e = entry_tab[ptr];
        if (gathered != e.length)
            return;
        if (e.scale_mode == sdp_pkg::MODE_RAW)
            value_tab[ptr] = assembly;
        else if (e.scale_mode == sdp_pkg::MODE_DIV10)
            value_tab[ptr] = assembly / 32'd10;
        if (int'(ptr) + 1 < used_entries())
        begin
            ptr = ptr + 4'd1;
            enter_idle();
        end
        else
        begin
            ptr = '0;
            ph = sdp_pkg::PH_WAIT;
        end
    endfunction

    function automatic void ms_tick();
        if (elapsed != sdp_pkg::ELAPSED_MAX)
            elapsed = elapsed + 16'd1;
        case (ph)
            sdp_pkg::PH_IDLE:
                if (elapsed >= cfg_pause)
                    send_request();
            sdp_pkg::PH_LISTEN:
                if (elapsed > cfg_timeout)
                begin
                    gathered = '0;
                    assembly = '0;
                    elapsed = '0;
                    ph = sdp_pkg::PH_SYNC;
                end
            sdp_pkg::PH_WAIT:
                if (elapsed > cfg_wait)
                begin
                    for (int i = 0; i < used_entries(); i++)
                        push_out(sdp_pkg::KIND_VALUE, 8'h00, 4'(i), value_tab[i]);
                    ph = sdp_pkg::PH_SYNC;
                end
            default: ;
        endcase
    endfunction

    function automatic void poll_step(sdp_pkg::cmd_item_t c);
        have_held = 1'b0;
        case (c.operation)
            sdp_pkg::OP_TICK: ms_tick();
            sdp_pkg::OP_BYTE:
                if (ph == sdp_pkg::PH_SYNC)
                begin
                    if (c.rx_byte == sdp_pkg::SYNC_BYTE)
                    begin
                        push_out(sdp_pkg::KIND_TX, sdp_pkg::ACK_BYTE, 4'd0, 32'd0);
                        enter_idle();
                    end
                end
                else if (ph == sdp_pkg::PH_LISTEN)
                    take_byte(c.rx_byte);
            sdp_pkg::OP_LOAD:
            begin
                entry_tab[c.load_index].address    = c.load_address;
                entry_tab[c.load_index].length     = c.load_length;
                entry_tab[c.load_index].scale_mode = c.load_scale_mode;
            end
            default: ;
        endcase
        if (have_held)
        begin
            held_out.last_of_run = 1'b1;
            link_out_q.push_back(held_out);
        end
    endfunction

    function automatic sdp_pkg::cmd_item_t mk_tick();
        sdp_pkg::cmd_item_t c;
        c = '0;
        c.operation = sdp_pkg::OP_TICK;
        return c;
    endfunction

    function automatic sdp_pkg::cmd_item_t mk_byte(logic [7:0] b);
        sdp_pkg::cmd_item_t c;
        c = '0;
        c.operation = sdp_pkg::OP_BYTE;
        c.rx_byte = b;
        return c;
    endfunction

    function automatic sdp_pkg::cmd_item_t mk_load(logic [3:0] idx, logic [15:0] adr,
                                                   logic [2:0] len, logic [1:0] mode);
        sdp_pkg::cmd_item_t c;
        c = '0;
        c.operation = sdp_pkg::OP_LOAD;
        c.load_index = idx;
        c.load_address = adr;
        c.load_length = len;
        c.load_scale_mode = mode;
        return c;
    endfunction

    // mostly well-formed traffic for the current phase, the rest random noise
    function automatic sdp_pkg::cmd_item_t pick_item();
        sdp_pkg::cmd_item_t c;
        sdp_pkg::entry_t e;
        c.operation = 2'($urandom);
        c.rx_byte = 8'($urandom);
        c.load_index = 4'($urandom);
        c.load_address = 16'($urandom);
        c.load_length = 3'($urandom);
        c.load_scale_mode = 2'($urandom);
        if ($urandom_range(0, 99) < 85)
        begin
            case (ph)
                sdp_pkg::PH_SYNC:
                begin
                    c.operation = sdp_pkg::OP_BYTE;
                    c.rx_byte = sdp_pkg::SYNC_BYTE;
                end
                sdp_pkg::PH_LISTEN:
                begin
                    e = entry_tab[ptr];
                    if (e.length >= 3'd1 && e.length <= 3'd4)
                        c.operation = ($urandom_range(0, 9) != 0) ? sdp_pkg::OP_BYTE
                                                                  : sdp_pkg::OP_TICK;
                    else if ($urandom_range(0, 1) == 0)
                    begin
                        c.operation = sdp_pkg::OP_LOAD;
                        c.load_index = ptr;
                        c.load_length = 3'($urandom_range(1, 4));
                    end
                    else
                        c.operation = sdp_pkg::OP_TICK;
                end
                default: c.operation = sdp_pkg::OP_TICK;
            endcase
        end
        return c;
    endfunction

    task automatic send_cmd(input sdp_pkg::cmd_item_t c);
        int gap;
        if (idling && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_item <= c;
        forever
        begin
            @(posedge clk);
            if (!cmd_stall)
                break;
        end
        poll_step(c);
        items_sent++;
    endtask

    task automatic random_run(input int n);
        repeat (n) send_cmd(pick_item());
    endtask

    task automatic settle();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (link_out_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            sdp_pkg::REG_ENTRIES_USED:  cfg_entries = data[4:0];
            sdp_pkg::REG_IDLE_PAUSE:    cfg_pause = data;
            sdp_pkg::REG_REPLY_TIMEOUT: cfg_timeout = data;
            sdp_pkg::REG_CYCLE_WAIT:    cfg_wait = data;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [4:0] entries, input logic [15:0] pause,
                                 input logic [15:0] timeout, input logic [15:0] wait_ms);
        settle();
        write_reg(sdp_pkg::REG_ENTRIES_USED, 16'(entries));
        write_reg(sdp_pkg::REG_IDLE_PAUSE, pause);
        write_reg(sdp_pkg::REG_REPLY_TIMEOUT, timeout);
        write_reg(sdp_pkg::REG_CYCLE_WAIT, wait_ms);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic test_directed();
        sdp_pkg::cmd_item_t reserved;
        apply_setting(5'd3, 16'd0, 16'd2, 16'd1);
        send_cmd(mk_load(4'd0, 16'hFFFF, 3'd4, sdp_pkg::MODE_RAW));
        send_cmd(mk_load(4'd1, 16'h0000, 3'd1, sdp_pkg::MODE_DIV10));
        send_cmd(mk_load(4'd2, 16'h1234, 3'd2, MODE_ODD));
        send_cmd(mk_load(4'd15, 16'hA5C3, 3'd7, MODE_KEEP));
        // drop: reserved operation
        reserved = '1;
        send_cmd(reserved);
        send_cmd(mk_byte(8'hFF));
        send_cmd(mk_byte(sdp_pkg::SYNC_BYTE));
        repeat (4) send_cmd(mk_byte(8'hFF));
        send_cmd(mk_byte(8'd99));
        send_cmd(mk_tick());
        send_cmd(mk_byte(8'hAA));
        send_cmd(mk_byte(8'h55));
        send_cmd(mk_byte(sdp_pkg::SYNC_BYTE));
        send_cmd(mk_tick());
        send_cmd(mk_byte(sdp_pkg::SYNC_BYTE));
        repeat (3) send_cmd(mk_tick());
        apply_setting(5'd0, 16'd2, 16'd3, 16'd1);
        send_cmd(mk_byte(sdp_pkg::SYNC_BYTE));
        send_cmd(mk_byte(8'h37));
        repeat (2) send_cmd(mk_tick());
        send_cmd(mk_byte(8'h00));
        send_cmd(mk_byte(8'h80));
        send_cmd(mk_byte(8'h7F));
        send_cmd(mk_byte(8'h01));
        repeat (2) send_cmd(mk_tick());
    endtask

    task automatic test_random_polling();
        for (int i = 0; i < 16; i++)
            send_cmd(mk_load(4'(i), 16'($urandom),
                             ($urandom_range(0, 7) == 0) ? 3'($urandom)
                                                        : 3'($urandom_range(1, 4)),
                             2'($urandom)));
        apply_setting(5'd31, 16'd0, 16'd1, 16'd1);
        random_run(50);
        apply_setting(5'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_run(15);
        repeat (2)
        begin
            apply_setting(5'($urandom_range(2, 16)), 16'($urandom_range(0, 3)),
                          16'($urandom_range(3, 8)), 16'($urandom_range(1, 6)));
            random_run(35);
        end
    endtask

    task automatic test_backpressure();
        apply_setting(5'd5, 16'd0, 16'd20, 16'd2);
        stall_hold = LONG_HOLD;
        random_run(45);
    endtask

    task automatic test_steady_stream();
        idling = 1'b0;
        apply_setting(5'd16, 16'($urandom_range(0, 2)), 16'd12, 16'd3);
        random_run(40);
    endtask

    initial
    begin : rsp_pacing
        int span;
        forever
        begin
            @(negedge clk);
            if (stall_hold > 0)
            begin
                span = stall_hold;
                stall_hold = 0;
                rsp_stall <= 1'b1;
                repeat (span) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else if (idling && $urandom_range(0, 7) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : out_check
        sdp_pkg::rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            outs_seen++;
            if (rsp_item.result_kind == sdp_pkg::KIND_VALUE)
                values_seen++;
            if (link_out_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected item, expected none, actual %0h", $time, rsp_item);
            end
            else
            begin
                want = link_out_q.pop_front();
                check_field("result_kind", 32'(want.result_kind), 32'(rsp_item.result_kind));
                check_field("tx_byte", 32'(want.tx_byte), 32'(rsp_item.tx_byte));
                check_field("published_index", 32'(want.published_index),
                            32'(rsp_item.published_index));
                check_field("published_value", want.published_value,
                            rsp_item.published_value);
                check_field("last_of_run", 32'(want.last_of_run), 32'(rsp_item.last_of_run));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d items still expected",
                         $time, quiet_cycles, link_out_q.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        cfg_entries = sdp_pkg::ENTRIES_USED_RST;
        cfg_pause = sdp_pkg::IDLE_PAUSE_RST;
        cfg_timeout = sdp_pkg::REPLY_TIMEOUT_RST;
        cfg_wait = sdp_pkg::CYCLE_WAIT_RST;
        ph = sdp_pkg::PH_SYNC;
        ptr = '0;
        gathered = '0;
        assembly = '0;
        elapsed = '0;
        for (int i = 0; i < 16; i++)
        begin
            entry_tab[i] = '0;
            value_tab[i] = '0;
        end
        have_held = 1'b0;
        held_out = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_polling();
        test_backpressure();
        test_steady_stream();

        settle();
        $display("Sent %0d command items over %0d register settings; checked %0d output items,",
                 items_sent, settings_applied, outs_seen);
        $display("%0d of them published values, with %0d mismatches.", values_seen, mismatches);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* serial_datapoint_poller_core.f */
hw/rtl/sdp_pkg.sv
hw/rtl/sdp_seq.sv
hw/rtl/sdp_dp.sv
hw/rtl/serial_datapoint_poller_core.sv
tb/serial_datapoint_poller_core_tb.sv
